// ===== hdl/srmcr_pkg.sv =====
// shared constants, codes and controller/datapath interface types
`default_nettype none
package srmcr_pkg;

  localparam int NUM_CHANNELS_DEF = 5;
  localparam int FRAME_SLOTS      = 5;

  localparam int ACT_W      = 2;
  localparam int CH_W       = 3;
  localparam int SAMPLE_W   = 12;
  localparam int CODE_W     = 12;
  localparam int DIVR_W     = 8;
  localparam int SUM_W      = 32;
  localparam int AVG_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int ID_W       = 11;
  localparam int LEN_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;
  localparam int DIV_NUM_W  = 32;
  localparam int DIV_DEN_W  = 12;
  localparam int NUM_REP_W  = 23;

  // action codes carried on in_tuser
  localparam logic [ACT_W-1:0] ACT_SAMPLE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_AVERAGE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REPORT  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR = 2'd3;

  localparam logic [CH_W-1:0]   ACTIVE_RST  = 3'd5;
  localparam logic [CODE_W-1:0] LOW_RST     = 12'd373;
  localparam logic [CODE_W-1:0] HIGH_RST    = 12'd3723;
  localparam logic [DIVR_W-1:0] DIVISOR_RST = 8'd10;

  localparam logic [ID_W-1:0] ID_ERROR   = 11'h005;
  localparam logic [ID_W-1:0] ID_RESTORE = 11'h006;
  localparam logic [ID_W-1:0] ID_DATA0   = 11'h035;
  localparam logic [ID_W-1:0] ID_DATA1   = 11'h036;

  localparam logic [LEN_W-1:0] LEN_ERROR   = 3'd2;
  localparam logic [LEN_W-1:0] LEN_RESTORE = 3'd1;
  localparam logic [LEN_W-1:0] LEN_DATA0   = 3'd4;
  localparam logic [LEN_W-1:0] LEN_DATA1   = 3'd1;

  localparam logic [BYTE_W-1:0] CHAR_E = 8'h45;
  localparam logic [BYTE_W-1:0] CHAR_R = 8'h52;

  localparam logic [6:0] PCT_FULL = 7'd100;

  typedef struct packed {
    logic sample_add;
    logic first_ch;
    logic report_clear;
    logic div_start;
    logic store;
    logic next_ch;
    logic mode_report;
    logic load_err;
    logic load_rst;
    logic load_d0;
    logic load_d1;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic idx_last;
    logic div_done;
    logic err_pending;
    logic err_single;
    logic link_ok;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== hdl/srmcr_divider.sv =====
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module srmcr_divider (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [srmcr_pkg::DIV_NUM_W-1:0]  num,
  input  wire logic [srmcr_pkg::DIV_DEN_W-1:0]  den,
  output logic                                  done,
  output logic      [srmcr_pkg::DIV_NUM_W-1:0]  quo
);

  localparam int NumW = srmcr_pkg::DIV_NUM_W;
  localparam int DenW = srmcr_pkg::DIV_DEN_W;
  localparam int CntW = $clog2(NumW);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CntW-1:0] cnt_r;
  logic [NumW-1:0] quo_r;
  logic [DenW-1:0] rem_r;
  logic [DenW-1:0] den_r;
  logic [DenW:0]   rem_w;
  logic [DenW:0]   rem_sub;
  logic            ge;
  logic            cnt_end;

  assign rem_w   = {rem_r, quo_r[NumW-1]};
  assign rem_sub = rem_w - {1'b0, den_r};
  assign ge      = rem_w >= {1'b0, den_r};
  assign cnt_end = cnt_r == CntW'(NumW - 1);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_end) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
      cnt_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[NumW-2:0], ge};
      rem_r <= ge ? rem_sub[DenW-1:0] : rem_w[DenW-1:0];
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

// ===== hdl/srmcr_datapath.sv =====
// channel sums, averages, config registers, range check and frame register
`default_nettype none
module srmcr_datapath #(
  parameter int NUM_CHANNELS = srmcr_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [srmcr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [srmcr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic [srmcr_pkg::CH_W-1:0]        in_channel,
  input  wire logic [srmcr_pkg::SAMPLE_W-1:0]    in_sample,
  input  wire srmcr_pkg::cmd_t                   cmd,
  output srmcr_pkg::status_t                     st,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [srmcr_pkg::ID_W-1:0]        out_tuser,
  output logic      [srmcr_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                                   out_tlast
);

  localparam int ChW   = srmcr_pkg::CH_W;
  localparam int CodeW = srmcr_pkg::CODE_W;
  localparam int SumW  = srmcr_pkg::SUM_W;
  localparam int AvgW  = srmcr_pkg::AVG_W;
  localparam int ByteW = srmcr_pkg::BYTE_W;
  localparam int NumRW = srmcr_pkg::NUM_REP_W;
  localparam int DenW  = srmcr_pkg::DIV_DEN_W;
  localparam int NumW  = srmcr_pkg::DIV_NUM_W;
  localparam int IdxW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [ChW-1:0] NumCh = ChW'(NUM_CHANNELS);

  // configuration
  logic [ChW-1:0]                  active_r;
  logic [CodeW-1:0]                low_r;
  logic [CodeW-1:0]                high_r;
  logic [srmcr_pkg::DIVR_W-1:0]    divr_r;

  // channel state
  logic [SumW-1:0]         sums_r [NUM_CHANNELS];
  logic [AvgW-1:0]         avgs_r [NUM_CHANNELS];
  logic [ByteW-1:0]        data_r [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] err_r;
  logic                    link_r;
  logic [IdxW-1:0]         idx_r;
  logic                    bad_r;

  // output register
  logic                          out_valid_r;
  logic [srmcr_pkg::ID_W-1:0]    out_id_r;
  logic [srmcr_pkg::LEN_W-1:0]   out_len_r;
  logic [ByteW-1:0]              out_b0_r, out_b1_r, out_b2_r, out_b3_r;
  logic                          out_last_r;

  logic [ChW-1:0]   n_used;
  logic [IdxW-1:0]  rd_idx;
  logic [SumW-1:0]  sum_rd;
  logic [AvgW-1:0]  avg_rd;
  logic [SumW:0]    sum_ext;
  logic [SumW-1:0]  sum_sat;
  logic             ch_ok;
  logic [AvgW-1:0]  diff;
  logic             bad;
  logic [NumRW-1:0] num_rep;
  logic [DenW-1:0]  den_rep;
  logic [DenW-1:0]  den_avg;
  logic [NumW-1:0]  div_num;
  logic [DenW-1:0]  div_den;
  logic             div_done;
  logic [NumW-1:0]  quo;
  logic [AvgW-1:0]  avg_val;
  logic             rep_ok;
  logic [NUM_CHANNELS-1:0] err_rest;
  logic [IdxW-1:0]  low_idx;
  logic [ByteW-1:0] slot [srmcr_pkg::FRAME_SLOTS];

  logic [srmcr_pkg::ID_W-1:0]  f_id;
  logic [srmcr_pkg::LEN_W-1:0] f_len;
  logic [ByteW-1:0]            f_b0, f_b1, f_b2, f_b3;
  logic                        f_last;
  logic                        f_load;

  assign n_used = (active_r > NumCh) ? NumCh : active_r;
  assign rd_idx = cmd.sample_add ? in_channel[IdxW-1:0] : idx_r;
  assign sum_rd = sums_r[rd_idx];
  assign avg_rd = avgs_r[idx_r];
  assign ch_ok  = in_channel < n_used;

  // saturating accumulate
  assign sum_ext = {1'b0, sum_rd} + (SumW+1)'(in_sample);
  assign sum_sat = sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];

  // report operands: (avg - low) * 100 over (high - low)
  assign diff    = avg_rd - AvgW'(low_r);
  assign bad     = !(high_r > low_r) || (avg_rd < AvgW'(low_r));
  assign num_rep = NumRW'(diff) * NumRW'(srmcr_pkg::PCT_FULL);
  assign den_rep = high_r - low_r;
  assign den_avg = (divr_r == '0) ? DenW'(1) : DenW'(divr_r);
  assign div_num = cmd.mode_report ? NumW'(num_rep) : sum_rd;
  assign div_den = cmd.mode_report ? den_rep : den_avg;

  srmcr_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  assign avg_val = (quo[NumW-1:AvgW] != '0) ? '1 : quo[AvgW-1:0];
  assign rep_ok  = !bad_r && (quo[NumW-1:7] == '0) && (quo[6:0] <= srmcr_pkg::PCT_FULL);

  // lowest failing channel goes out first
  assign err_rest = err_r & (err_r - NUM_CHANNELS'(1));
  always_comb begin
    low_idx = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (err_r[i]) begin
        low_idx = IdxW'(i);
      end
    end
  end

  for (genvar j = 0; j < srmcr_pkg::FRAME_SLOTS; j++) begin : g_slot
    if (j < NUM_CHANNELS) begin : g_used
      assign slot[j] = data_r[j];
    end else begin : g_absent
      assign slot[j] = '0;
    end
  end

  always_comb begin
    f_id   = '0;
    f_len  = '0;
    f_b0   = '0;
    f_b1   = '0;
    f_b2   = '0;
    f_b3   = '0;
    f_last = 1'b0;
    f_load = cmd.load_err | cmd.load_rst | cmd.load_d0 | cmd.load_d1;
    priority if (cmd.load_err) begin
      f_id   = srmcr_pkg::ID_ERROR;
      f_len  = srmcr_pkg::LEN_ERROR;
      f_b0   = srmcr_pkg::CHAR_E;
      f_b1   = ByteW'(low_idx) + 1'b1;
      f_last = err_rest == '0;
    end else if (cmd.load_rst) begin
      f_id   = srmcr_pkg::ID_RESTORE;
      f_len  = srmcr_pkg::LEN_RESTORE;
      f_b0   = srmcr_pkg::CHAR_R;
    end else if (cmd.load_d0) begin
      f_id   = srmcr_pkg::ID_DATA0;
      f_len  = srmcr_pkg::LEN_DATA0;
      f_b0   = slot[0];
      f_b1   = slot[1];
      f_b2   = slot[2];
      f_b3   = slot[3];
    end else if (cmd.load_d1) begin
      f_id   = srmcr_pkg::ID_DATA1;
      f_len  = srmcr_pkg::LEN_DATA1;
      f_b0   = slot[4];
      f_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= srmcr_pkg::ACTIVE_RST;
      low_r       <= srmcr_pkg::LOW_RST;
      high_r      <= srmcr_pkg::HIGH_RST;
      divr_r      <= srmcr_pkg::DIVISOR_RST;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        sums_r[i] <= '0;
        avgs_r[i] <= '0;
      end
      err_r       <= '0;
      link_r      <= 1'b1;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          srmcr_pkg::CFG_ACTIVE:  active_r <= cfg_wdata[ChW-1:0];
          srmcr_pkg::CFG_LOW:     low_r    <= cfg_wdata[CodeW-1:0];
          srmcr_pkg::CFG_HIGH:    high_r   <= cfg_wdata[CodeW-1:0];
          srmcr_pkg::CFG_DIVISOR: divr_r   <= cfg_wdata[srmcr_pkg::DIVR_W-1:0];
        endcase
      end
      if (cmd.sample_add && ch_ok) begin
        sums_r[in_channel[IdxW-1:0]] <= sum_sat;
      end
      if (cmd.first_ch) begin
        idx_r <= '0;
      end else if (cmd.next_ch) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.report_clear) begin
        err_r <= '0;
      end else if (cmd.store && cmd.mode_report && !rep_ok) begin
        err_r[idx_r] <= 1'b1;
      end else if (cmd.load_err) begin
        err_r <= err_rest;
      end
      if (cmd.store && !cmd.mode_report) begin
        avgs_r[idx_r] <= avg_val;
        sums_r[idx_r] <= '0;
      end
      if (cmd.store && cmd.mode_report && !rep_ok) begin
        link_r <= 1'b0;
      end else if (cmd.load_rst) begin
        link_r <= 1'b1;
      end
      if (f_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report_clear) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        data_r[i] <= '0;
      end
    end else if (cmd.store && cmd.mode_report && rep_ok) begin
      data_r[idx_r] <= quo[ByteW-1:0];
    end
    if (cmd.div_start) begin
      bad_r <= bad;
    end
    if (f_load) begin
      out_id_r   <= f_id;
      out_len_r  <= f_len;
      out_b0_r   <= f_b0;
      out_b1_r   <= f_b1;
      out_b2_r   <= f_b2;
      out_b3_r   <= f_b3;
      out_last_r <= f_last;
    end
  end

  assign st.n_zero      = n_used == '0;
  assign st.idx_last    = ChW'(idx_r) == (n_used - 1'b1);
  assign st.div_done    = div_done;
  assign st.err_pending = err_r != '0;
  assign st.err_single  = err_rest == '0;
  assign st.link_ok     = link_r;
  assign st.out_free    = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_id_r;
  assign out_tdata  = {5'd0, out_b3_r, out_b2_r, out_b1_r, out_b0_r, out_len_r};
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// ===== hdl/srmcr_ctrl.sv =====
// sequencer for sample, average and report requests
`default_nettype none
module srmcr_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  input  wire logic [srmcr_pkg::ACT_W-1:0]   in_action,
  output logic                               in_tready,
  output srmcr_pkg::cmd_t                    cmd,
  input  wire srmcr_pkg::status_t            st
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_SETUP    = 8'b0000_0010,
    ST_DIVIDE   = 8'b0000_0100,
    ST_STORE    = 8'b0000_1000,
    ST_EMIT_ERR = 8'b0001_0000,
    ST_EMIT_RST = 8'b0010_0000,
    ST_EMIT_D0  = 8'b0100_0000,
    ST_EMIT_D1  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   mode_r, mode_nxt;

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.mode_report = mode_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (in_action)
            srmcr_pkg::ACT_SAMPLE: begin
              cmd.sample_add = 1'b1;
            end
            srmcr_pkg::ACT_AVERAGE: begin
              if (!st.n_zero) begin
                cmd.first_ch = 1'b1;
                mode_nxt     = 1'b0;
                state_nxt    = ST_SETUP;
              end
            end
            srmcr_pkg::ACT_REPORT: begin
              cmd.first_ch     = 1'b1;
              cmd.report_clear = 1'b1;
              mode_nxt         = 1'b1;
              state_nxt        = st.n_zero ? ST_EMIT_ERR : ST_SETUP;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SETUP: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (st.div_done) begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (st.idx_last) begin
          state_nxt = mode_r ? ST_EMIT_ERR : ST_IDLE;
        end else begin
          cmd.next_ch = 1'b1;
          state_nxt   = ST_SETUP;
        end
      end
      ST_EMIT_ERR: begin
        if (st.err_pending) begin
          if (st.out_free) begin
            cmd.load_err = 1'b1;
            if (st.err_single) begin
              state_nxt = ST_IDLE;
            end
          end
        end else begin
          state_nxt = st.link_ok ? ST_EMIT_D0 : ST_EMIT_RST;
        end
      end
      ST_EMIT_RST: begin
        if (st.out_free) begin
          cmd.load_rst = 1'b1;
          state_nxt    = ST_EMIT_D0;
        end
      end
      ST_EMIT_D0: begin
        if (st.out_free) begin
          cmd.load_d0 = 1'b1;
          state_nxt   = ST_EMIT_D1;
        end
      end
      ST_EMIT_D1: begin
        if (st.out_free) begin
          cmd.load_d1 = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sensor_range_monitor_can_reporter_core.sv =====
// top level of the sensor range monitor with frame reporter
//
// A sample request is folded into its channel's saturating sum. An average
// or report request walks the active channels one after the other through a
// shared one-bit-per-cycle divider, with operand setup, 32 divide steps, done
// and writeback for each channel; no request is taken meanwhile. A report then
// loads one frame per cycle into the output register as long as the receiver
// keeps up: the error frames in channel order, or, after a state that picks
// the path, the optional restore frame followed by the two data frames.
// A new request is taken as soon as the last frame sits in the output
// register, even while it waits to be taken.
`default_nettype none
module sensor_range_monitor_can_reporter_core #(
  parameter int NUM_CHANNELS = srmcr_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [srmcr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [srmcr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // action [1:0]
  input  wire logic [srmcr_pkg::ACT_W-1:0]       in_tuser,
  // channel [2:0], sample_value [14:3], zero [15]
  input  wire logic [srmcr_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // frame_id [10:0]
  output logic      [srmcr_pkg::ID_W-1:0]        out_tuser,
  // frame_length [2:0], byte0 [10:3], byte1 [18:11], byte2 [26:19],
  // byte3 [34:27], zero [39:35]
  output logic      [srmcr_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                                   out_tlast
);

  srmcr_pkg::cmd_t    cmd;
  srmcr_pkg::status_t st;

  srmcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (in_tuser),
    .in_tready (in_tready),
    .cmd       (cmd),
    .st        (st)
  );

  srmcr_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_channel (in_tdata[srmcr_pkg::CH_W-1:0]),
    .in_sample  (in_tdata[srmcr_pkg::CH_W +: srmcr_pkg::SAMPLE_W]),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ===== hdl/srmcr_checker.sv =====
// port-level checks on the frame stream, bound to the top level
`default_nettype none
module srmcr_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic [srmcr_pkg::ACT_W-1:0]       in_tuser,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [srmcr_pkg::ID_W-1:0]        out_tuser,
  input wire logic [srmcr_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire logic                              out_tlast
);

  // a stalled frame stays put
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled frame changed");

  // a report request always takes the block out of idle, so ready drops
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == srmcr_pkg::ACT_REPORT |=> !in_tready)
    else $error("ready right after report request");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == srmcr_pkg::ID_ERROR || out_tuser == srmcr_pkg::ID_RESTORE
      || out_tuser == srmcr_pkg::ID_DATA0 || out_tuser == srmcr_pkg::ID_DATA1)
    else $error("unexpected frame id");

  // error frames carry the marker and a one-based channel
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == srmcr_pkg::ID_ERROR |->
      out_tdata[2:0] == srmcr_pkg::LEN_ERROR && out_tdata[10:3] == srmcr_pkg::CHAR_E
      && out_tdata[18:11] != 8'd0)
    else $error("malformed error frame");

  // the first data frame is never last, the second always is
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser != srmcr_pkg::ID_DATA0 || !out_tlast)
      && (out_tuser != srmcr_pkg::ID_DATA1 || out_tlast))
    else $error("wrong last marker on data frame");

endmodule

bind sensor_range_monitor_can_reporter_core srmcr_checker u_srmcr_checker (.*);
`default_nettype wire
